[sv/ps2d_pkg.sv]
// package: types, byte codes and prefix decode functions for the ps2 scan code decoder
`default_nettype none
package ps2d_pkg;

  localparam int MAX_EVENTS = 6;  // events one scan byte can produce
  localparam int PASS_EVENTS = 5; // events one decode pass can produce
  localparam int PASS_MAX = 3;    // longest unwind chain: prefix, shorter prefix, base

  // scan bytes with a meaning
  localparam logic [7:0] BYTE_E0 = 8'he0;
  localparam logic [7:0] BYTE_E1 = 8'he1;
  localparam logic [7:0] BYTE_F0 = 8'hf0;
  localparam logic [7:0] BYTE_2A = 8'h2a;
  localparam logic [7:0] BYTE_B7 = 8'hb7;
  localparam logic [7:0] BYTE_37 = 8'h37;
  localparam logic [7:0] BYTE_AA = 8'haa;
  localparam logic [7:0] BYTE_1D = 8'h1d;
  localparam logic [7:0] BYTE_45 = 8'h45;
  localparam logic [7:0] BYTE_9D = 8'h9d;
  localparam logic [7:0] BYTE_7C = 8'h7c;
  localparam logic [7:0] BYTE_12 = 8'h12;
  localparam logic [7:0] BYTE_14 = 8'h14;
  localparam logic [7:0] BYTE_77 = 8'h77;

  // translation table codes
  localparam logic [2:0] TBL_S1_BASE = 3'd0;
  localparam logic [2:0] TBL_S1_E0   = 3'd1;
  localparam logic [2:0] TBL_S2_BASE = 3'd2;
  localparam logic [2:0] TBL_S2_E0   = 3'd3;
  localparam logic [2:0] TBL_S3      = 3'd4;
  localparam logic [2:0] TBL_SPECIAL = 3'd5;

  // special key tags
  localparam logic [1:0] SPC_NONE  = 2'd0;
  localparam logic [1:0] SPC_PRTSC = 2'd1;
  localparam logic [1:0] SPC_PAUSE = 2'd2;

  // scan set register codes
  localparam logic [1:0] SET_1 = 2'd1;
  localparam logic [1:0] SET_2 = 2'd2;
  localparam logic [1:0] SET_3 = 2'd3;

  typedef enum logic [28:0] {
    ST_S1          = 29'h1 << 0,
    ST_S1_E0       = 29'h1 << 1,
    ST_S1_E0_2A    = 29'h1 << 2,
    ST_S1_E0_2A_E0 = 29'h1 << 3,
    ST_S1_E0_B7    = 29'h1 << 4,
    ST_S1_E0_B7_E0 = 29'h1 << 5,
    ST_S1_E1       = 29'h1 << 6,
    ST_S1_P1       = 29'h1 << 7,   // e1 1d
    ST_S1_P2       = 29'h1 << 8,   // e1 1d 45
    ST_S1_P3       = 29'h1 << 9,   // e1 1d 45 e1
    ST_S1_P4       = 29'h1 << 10,  // e1 1d 45 e1 9d
    ST_S2          = 29'h1 << 11,
    ST_S2_F0       = 29'h1 << 12,
    ST_S2_E0       = 29'h1 << 13,
    ST_S2_E0_F0    = 29'h1 << 14,
    ST_S2_E0_12    = 29'h1 << 15,
    ST_S2_E0_12_E0 = 29'h1 << 16,
    ST_S2_R1       = 29'h1 << 17,  // e0 f0 7c
    ST_S2_R2       = 29'h1 << 18,  // e0 f0 7c e0
    ST_S2_R3       = 29'h1 << 19,  // e0 f0 7c e0 f0
    ST_S2_E1       = 29'h1 << 20,
    ST_S2_P1       = 29'h1 << 21,  // e1 14
    ST_S2_P2       = 29'h1 << 22,  // e1 14 77
    ST_S2_P3       = 29'h1 << 23,  // e1 14 77 e1
    ST_S2_P4       = 29'h1 << 24,  // e1 14 77 e1 f0
    ST_S2_P5       = 29'h1 << 25,  // e1 14 77 e1 f0 14
    ST_S2_P6       = 29'h1 << 26,  // e1 14 77 e1 f0 14 f0
    ST_S3          = 29'h1 << 27,
    ST_S3_F0       = 29'h1 << 28
  } state_t;

  typedef struct packed {
    logic [2:0] table_select;
    logic [7:0] key_code;
    logic       released;
    logic [1:0] special_key;
  } key_event_t;

  typedef struct packed {
    state_t                            next;
    logic                              again;
    logic [2:0]                        n_ev;
    key_event_t [PASS_EVENTS-1:0]      ev;
  } pass_t;

  typedef struct packed {
    state_t                       next;
    logic [2:0]                   n_ev;
    key_event_t [MAX_EVENTS-1:0]  ev;
  } decode_t;

  // decoder to event queue: one byte's events
  typedef struct packed {
    logic                         valid;
    logic [2:0]                   n_ev;
    key_event_t [MAX_EVENTS-1:0]  ev;
  } ev_load_t;

  function automatic key_event_t mk_ev(logic [2:0] tbl, logic [7:0] code,
                                       logic rel, logic [1:0] spec);
    key_event_t e;
    e.table_select = tbl;
    e.key_code     = code;
    e.released     = rel;
    e.special_key  = spec;
    return e;
  endfunction

  // pending bytes of the set 1 pause prefix e1 1d 45 e1
  function automatic key_event_t [PASS_EVENTS-1:0] pause1_seq();
    key_event_t [PASS_EVENTS-1:0] s;
    s    = '0;
    s[0] = mk_ev(TBL_S1_BASE, BYTE_E1, 1'b0, SPC_NONE);
    s[1] = mk_ev(TBL_S1_BASE, BYTE_1D, 1'b0, SPC_NONE);
    s[2] = mk_ev(TBL_S1_BASE, BYTE_45, 1'b0, SPC_NONE);
    s[3] = mk_ev(TBL_S1_BASE, BYTE_E1, 1'b0, SPC_NONE);
    return s;
  endfunction

  // pending bytes of the set 2 pause prefix e1 14 77 e1 f0-14
  function automatic key_event_t [PASS_EVENTS-1:0] pause2_seq();
    key_event_t [PASS_EVENTS-1:0] s;
    s[0] = mk_ev(TBL_S2_BASE, BYTE_E1, 1'b0, SPC_NONE);
    s[1] = mk_ev(TBL_S2_BASE, BYTE_14, 1'b0, SPC_NONE);
    s[2] = mk_ev(TBL_S2_BASE, BYTE_77, 1'b0, SPC_NONE);
    s[3] = mk_ev(TBL_S2_BASE, BYTE_E1, 1'b0, SPC_NONE);
    s[4] = mk_ev(TBL_S2_BASE, BYTE_14, 1'b1, SPC_NONE);
    return s;
  endfunction

  function automatic state_t base_of(logic [1:0] set);
    state_t s;
    priority if (set == SET_3) begin
      s = ST_S3;
    end else if (set == SET_2) begin
      s = ST_S2;
    end else begin
      s = ST_S1;  // set 0 counts as set 1
    end
    return s;
  endfunction

  // one pass of the prefix machine; again asks to rerun the byte from next
  function automatic pass_t dec_pass(state_t s, logic [7:0] b);
    pass_t p;
    p       = '0;
    p.next  = s;
    p.again = 1'b0;
    unique case (s)
      ST_S1: begin
        if (b == BYTE_E0) begin
          p.next = ST_S1_E0;
        end else if (b == BYTE_E1) begin
          p.next = ST_S1_E1;
        end else begin
          p.ev[0] = mk_ev(TBL_S1_BASE, b, 1'b0, SPC_NONE); p.n_ev = 3'd1;
        end
      end
      ST_S1_E0: begin
        if (b == BYTE_2A) begin
          p.next = ST_S1_E0_2A;
        end else if (b == BYTE_B7) begin
          p.next = ST_S1_E0_B7;
        end else begin
          p.ev[0] = mk_ev(TBL_S1_E0, b, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S1;
        end
      end
      ST_S1_E0_2A: begin
        if (b == BYTE_E0) begin
          p.next = ST_S1_E0_2A_E0;
        end else begin
          p.ev[0] = mk_ev(TBL_S1_E0, BYTE_2A, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S1; p.again = 1'b1;
        end
      end
      ST_S1_E0_2A_E0: begin
        if (b == BYTE_37) begin
          p.ev[0] = mk_ev(TBL_SPECIAL, 8'h00, 1'b0, SPC_PRTSC); p.n_ev = 3'd1;
          p.next = ST_S1;
        end else begin
          p.ev[0] = mk_ev(TBL_S1_E0, BYTE_2A, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S1_E0; p.again = 1'b1;
        end
      end
      ST_S1_E0_B7: begin
        if (b == BYTE_E0) begin
          p.next = ST_S1_E0_B7_E0;
        end else begin
          p.ev[0] = mk_ev(TBL_S1_E0, BYTE_B7, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S1; p.again = 1'b1;
        end
      end
      ST_S1_E0_B7_E0: begin
        if (b == BYTE_AA) begin
          p.ev[0] = mk_ev(TBL_SPECIAL, 8'h00, 1'b1, SPC_PRTSC); p.n_ev = 3'd1;
          p.next = ST_S1;
        end else begin
          p.ev[0] = mk_ev(TBL_S1_E0, BYTE_B7, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S1_E0; p.again = 1'b1;
        end
      end
      ST_S1_E1: begin
        if (b == BYTE_1D) begin
          p.next = ST_S1_P1;
        end else begin
          p.ev = pause1_seq(); p.n_ev = 3'd1; p.next = ST_S1; p.again = 1'b1;
        end
      end
      ST_S1_P1: begin
        if (b == BYTE_45) begin
          p.next = ST_S1_P2;
        end else begin
          p.ev = pause1_seq(); p.n_ev = 3'd2; p.next = ST_S1; p.again = 1'b1;
        end
      end
      ST_S1_P2: begin
        if (b == BYTE_E1) begin
          p.next = ST_S1_P3;
        end else begin
          p.ev = pause1_seq(); p.n_ev = 3'd3; p.next = ST_S1; p.again = 1'b1;
        end
      end
      ST_S1_P3: begin
        if (b == BYTE_9D) begin
          p.next = ST_S1_P4;
        end else begin
          p.ev = pause1_seq(); p.n_ev = 3'd3; p.next = ST_S1_E1; p.again = 1'b1;
        end
      end
      ST_S1_P4: begin
        p.next = ST_S1;
        if (b == BYTE_9D) begin
          p.ev[0] = mk_ev(TBL_SPECIAL, 8'h00, 1'b0, SPC_PAUSE);
          p.ev[1] = mk_ev(TBL_SPECIAL, 8'h00, 1'b1, SPC_PAUSE);
          p.n_ev  = 3'd2;
        end else begin
          p.ev = pause1_seq(); p.n_ev = 3'd4; p.again = 1'b1;
        end
      end
      ST_S2_F0: begin
        p.ev[0] = mk_ev(TBL_S2_BASE, b, 1'b1, SPC_NONE); p.n_ev = 3'd1;
        p.next = ST_S2;
      end
      ST_S2_E0: begin
        if (b == BYTE_F0) begin
          p.next = ST_S2_E0_F0;
        end else if (b == BYTE_12) begin
          p.next = ST_S2_E0_12;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_E0, b, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2;
        end
      end
      ST_S2_E0_F0: begin
        if (b == BYTE_7C) begin
          p.next = ST_S2_R1;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_E0, b, 1'b1, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2;
        end
      end
      ST_S2_E0_12: begin
        if (b == BYTE_E0) begin
          p.next = ST_S2_E0_12_E0;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_E0, BYTE_12, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2; p.again = 1'b1;
        end
      end
      ST_S2_E0_12_E0: begin
        if (b == BYTE_7C) begin
          p.ev[0] = mk_ev(TBL_SPECIAL, 8'h00, 1'b0, SPC_PRTSC); p.n_ev = 3'd1;
          p.next = ST_S2;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_E0, BYTE_12, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2_E0; p.again = 1'b1;
        end
      end
      ST_S2_R1: begin
        if (b == BYTE_E0) begin
          p.next = ST_S2_R2;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_E0, BYTE_7C, 1'b1, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2; p.again = 1'b1;
        end
      end
      ST_S2_R2: begin
        if (b == BYTE_F0) begin
          p.next = ST_S2_R3;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_E0, BYTE_7C, 1'b1, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2_E0; p.again = 1'b1;
        end
      end
      ST_S2_R3: begin
        if (b == BYTE_12) begin
          p.ev[0] = mk_ev(TBL_SPECIAL, 8'h00, 1'b1, SPC_PRTSC); p.n_ev = 3'd1;
          p.next = ST_S2;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_E0, BYTE_7C, 1'b1, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2_E0_F0; p.again = 1'b1;
        end
      end
      ST_S2_E1: begin
        if (b == BYTE_14) begin
          p.next = ST_S2_P1;
        end else begin
          p.ev = pause2_seq(); p.n_ev = 3'd1; p.next = ST_S2; p.again = 1'b1;
        end
      end
      ST_S2_P1: begin
        if (b == BYTE_77) begin
          p.next = ST_S2_P2;
        end else begin
          p.ev = pause2_seq(); p.n_ev = 3'd2; p.next = ST_S2; p.again = 1'b1;
        end
      end
      ST_S2_P2: begin
        if (b == BYTE_E1) begin
          p.next = ST_S2_P3;
        end else begin
          p.ev = pause2_seq(); p.n_ev = 3'd3; p.next = ST_S2; p.again = 1'b1;
        end
      end
      ST_S2_P3: begin
        if (b == BYTE_F0) begin
          p.next = ST_S2_P4;
        end else begin
          p.ev = pause2_seq(); p.n_ev = 3'd3; p.next = ST_S2_E1; p.again = 1'b1;
        end
      end
      ST_S2_P4: begin
        if (b == BYTE_14) begin
          p.next = ST_S2_P5;
        end else begin
          p.ev = pause2_seq(); p.n_ev = 3'd4; p.next = ST_S2_F0; p.again = 1'b1;
        end
      end
      ST_S2_P5: begin
        if (b == BYTE_F0) begin
          p.next = ST_S2_P6;
        end else begin
          p.ev = pause2_seq(); p.n_ev = 3'd5; p.next = ST_S2; p.again = 1'b1;
        end
      end
      ST_S2_P6: begin
        if (b == BYTE_12) begin
          p.ev[0] = mk_ev(TBL_SPECIAL, 8'h00, 1'b0, SPC_PAUSE);
          p.ev[1] = mk_ev(TBL_SPECIAL, 8'h00, 1'b1, SPC_PAUSE);
          p.n_ev  = 3'd2;
          p.next  = ST_S2;
        end else begin
          p.ev = pause2_seq(); p.n_ev = 3'd5; p.next = ST_S2_F0; p.again = 1'b1;
        end
      end
      ST_S3: begin
        if (b == BYTE_F0) begin
          p.next = ST_S3_F0;
        end else begin
          p.ev[0] = mk_ev(TBL_S3, b, 1'b0, SPC_NONE); p.n_ev = 3'd1;
        end
      end
      ST_S3_F0: begin
        p.ev[0] = mk_ev(TBL_S3, b, 1'b1, SPC_NONE); p.n_ev = 3'd1;
        p.next = ST_S3;
      end
      default: begin  // set 2 base
        if (b == BYTE_F0) begin
          p.next = ST_S2_F0;
        end else if (b == BYTE_E0) begin
          p.next = ST_S2_E0;
        end else if (b == BYTE_E1) begin
          p.next = ST_S2_E1;
        end else begin
          p.ev[0] = mk_ev(TBL_S2_BASE, b, 1'b0, SPC_NONE); p.n_ev = 3'd1;
          p.next = ST_S2;
        end
      end
    endcase
    return p;
  endfunction

  // full decode of one byte: chained passes, events appended in order
  function automatic decode_t dec_byte(state_t s, logic [7:0] b);
    decode_t                      d;
    pass_t                        p;
    state_t                       cur;
    logic                         run;
    logic [2:0]                   cnt;
    logic [3:0]                   idx;
    logic [3:0]                   sum;
    key_event_t [MAX_EVENTS-1:0]  lst;
    cur = s;
    run = 1'b1;
    cnt = '0;
    lst = '0;
    for (int k = 0; k < PASS_MAX; k++) begin
      if (run) begin
        p = dec_pass(cur, b);
        for (int j = 0; j < PASS_EVENTS; j++) begin
          idx = 4'(cnt) + 4'(j);
          if ((3'(j) < p.n_ev) && (idx < 4'(MAX_EVENTS))) begin
            lst[idx[2:0]] = p.ev[j];
          end
        end
        sum = 4'(cnt) + 4'(p.n_ev);
        cnt = (sum > 4'(MAX_EVENTS)) ? 3'(MAX_EVENTS) : sum[2:0];
        cur = p.next;
        run = p.again;
      end
    end
    d.next = cur;
    d.n_ev = cnt;
    d.ev   = lst;
    return d;
  endfunction

endpackage
`default_nettype wire

[sv/ps2d_byte_if.sv]
// interface: scan byte channel
`default_nettype none
interface ps2d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface
`default_nettype wire

[sv/ps2d_event_if.sv]
// interface: key event channel
`default_nettype none
interface ps2d_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] table_select;
  logic [7:0] key_code;
  logic       released;
  logic [1:0] special_key;
  logic       last_event;

  modport source (output valid, output table_select, output key_code, output released,
                  output special_key, output last_event, input ready);
  modport sink   (input valid, input table_select, input key_code, input released,
                  input special_key, input last_event, output ready);
endinterface
`default_nettype wire

[sv/ps2d_decode.sv]
// module: byte input register, prefix state register and per-byte decode
`default_nettype none
module ps2d_decode (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_data,
  ps2d_byte_if.sink           scan,
  input  wire logic           q_free,
  output ps2d_pkg::ev_load_t  load
);

  logic               byte_valid;
  logic [7:0]         byte_q;
  ps2d_pkg::state_t   state;
  ps2d_pkg::decode_t  dec;
  logic               advance;

  always_comb begin
    dec = ps2d_pkg::dec_byte(state, byte_q);
  end

  // a byte with no events only moves the state, it never waits on the queue
  assign advance    = byte_valid && ((dec.n_ev == 3'd0) || q_free);
  assign scan.ready = !byte_valid || advance;

  assign load.valid = advance && (dec.n_ev != 3'd0);
  assign load.n_ev  = dec.n_ev;
  assign load.ev    = dec.ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (scan.valid && scan.ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      byte_q <= scan.scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ps2d_pkg::ST_S2;
    end else if (cfg_we) begin
      state <= ps2d_pkg::base_of(cfg_data);
    end else if (advance) begin
      state <= dec.next;
    end
  end

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load.valid |-> (load.n_ev != 3'd0) && (load.n_ev <= 3'(ps2d_pkg::MAX_EVENTS)))
    else $error("event load count out of range");

  a_cfg_base: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == ps2d_pkg::ST_S1) || (state == ps2d_pkg::ST_S2) ||
               (state == ps2d_pkg::ST_S3))
    else $error("scan set write did not land in a base state");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("prefix state lost its one-hot code");

endmodule
`default_nettype wire

[sv/ps2d_event_queue.sv]
// module: event shift queue that drains one byte's events one word per cycle while keys is ready
`default_nettype none
module ps2d_event_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  ps2d_pkg::ev_load_t  load,
  output logic                q_free,
  ps2d_event_if.source        keys
);

  ps2d_pkg::key_event_t          ev_buf [ps2d_pkg::MAX_EVENTS];
  logic [ps2d_pkg::MAX_EVENTS-1:0] last_buf;
  logic [2:0]                    cnt;
  logic                          pop;

  assign keys.valid        = (cnt != 3'd0);
  assign keys.table_select = ev_buf[0].table_select;
  assign keys.key_code     = ev_buf[0].key_code;
  assign keys.released     = ev_buf[0].released;
  assign keys.special_key  = ev_buf[0].special_key;
  assign keys.last_event   = last_buf[0];

  assign pop    = keys.valid && keys.ready;
  // empty, or the final word of the current byte leaves this cycle
  assign q_free = (cnt == 3'd0) || ((cnt == 3'd1) && keys.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load.valid) begin
      cnt <= load.n_ev;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      for (int i = 0; i < ps2d_pkg::MAX_EVENTS; i++) begin
        ev_buf[i]   <= load.ev[i];
        last_buf[i] <= (3'(i) == (load.n_ev - 3'd1));
      end
    end else if (pop) begin
      for (int i = 0; i < ps2d_pkg::MAX_EVENTS - 1; i++) begin
        ev_buf[i]   <= ev_buf[i+1];
        last_buf[i] <= last_buf[i+1];
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load.valid |-> (cnt == 3'd0) || ((cnt == 3'd1) && pop))
    else $error("events loaded over undelivered words");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    keys.valid |-> (keys.last_event == (cnt == 3'd1)))
    else $error("last event mark out of step with queue count");

endmodule
`default_nettype wire

[sv/ps2_scan_code_prefix_decoder_top.sv]
// top level: ps2 scan code prefix decoder for scan sets 1, 2 and 3
//
// scan channel: one received keyboard byte per word (valid/ready)
// keys channel: one key event per word: table_select, key_code, released,
//   special_key, and last_event set on the final event of a byte
// cfg_we/cfg_data: scan set select; a write also returns the prefix
//   machine to that set's base state, set 0 acts as set 1; write only idle
//
// a byte lands in an input register; from there the whole prefix decode
// (including unwinding a broken multi-byte sequence and re-running the byte)
// runs in one combinational pass and loads its 0..6 events into a shift queue
// throughput: one byte per cycle for bytes with no event, and for bytes with
//   one event while keys is ready; a byte with n events drains from the queue
//   one event word per cycle while keys is ready
// the next byte is taken while the queue drains; a byte with events waits in
//   the input register until the last word of the previous byte leaves
// reset: scan set 2 base state, queue and input register empty
// a stalled keys receiver holds the queue word and backs up into scan.ready
`default_nettype none
module ps2_scan_code_prefix_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_data,
  ps2d_byte_if.sink       scan,
  ps2d_event_if.source    keys
);

  ps2d_pkg::ev_load_t load;   // one byte's decoded events
  logic               q_free; // queue can take a new byte's events

  // input register, prefix state and decode
  ps2d_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .scan     (scan),
    .q_free   (q_free),
    .load     (load)
  );

  // event words out, one per cycle while keys is ready
  ps2d_event_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .q_free (q_free),
    .keys   (keys)
  );

endmodule
`default_nettype wire

[verif/ps2_scan_code_prefix_decoder_top_test.sv]
// testbench: scan byte prefix decoding in all three scan sets, checked word by word
module ps2_scan_code_prefix_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2d_pkg::*;

  // scan set register value 0 has no package name; the block treats it as set 1
  localparam logic [1:0] SET_ZERO = 2'd0;

  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = 8;       // lets prefix bytes clear the input register, with margin
  localparam int DRAIN_CYCLES  = 20;      // watch for stray words after the last one
  localparam int HOLD_CYCLES   = 300;     // long receiver stall to back up the input
  localparam int CYCLE_LIMIT   = 200000;  // hard stop for a run that hangs
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_BYTES   = 64;      // random bytes per phase, about 390 in all
  localparam int DIRECTED_ROWS = 26;

  // scan set written at the start of each random phase
  localparam logic [1:0] PHASE_SET [PHASE_COUNT] =
    '{SET_2, SET_1, SET_3, SET_ZERO, SET_3, SET_2};

  typedef enum logic {ROW_BYTE, ROW_SET} row_kind_t;

  // one directed row: a scan byte or a scan set write; typed rows carry their
  // single expected event, all others go through the predictor
  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    logic       typed;
    key_event_t typed_ev;
  } stim_row_t;

  // one expected word on the keys channel
  typedef struct packed {
    key_event_t ev;
    logic       last_ev;
  } key_word_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_data;

  ps2d_byte_if  scan_ch ();
  ps2d_event_if key_ch ();

  ps2_scan_code_prefix_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .scan     (scan_ch),
    .keys     (key_ch)
  );

  // predictor copy of the block's state and register
  logic [1:0] active_set;
  state_t     prefix_state;
  key_event_t byte_events [$];   // events of the byte being predicted
  key_word_t  key_words_due [$]; // expected words, oldest first
  logic [7:0] stim_bytes [$];    // random sequence waiting to be sent

  int src_idle_pct;
  int sink_idle_pct;
  bit hold_armed;
  bit hold_started;
  int hold_left;
  int mismatch_count;
  int bytes_sent;
  int events_checked;
  int cycle_count;

  // directed rows: extremes after reset, print screen sequences whole and broken,
  // set 3 release, set zero written, set 1 pause
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // set 2 after reset: code extremes
    '{ROW_BYTE, 8'h00, 1'b1, '{TBL_S2_BASE, 8'h00, 1'b0, SPC_NONE}},
    '{ROW_BYTE, 8'hff, 1'b1, '{TBL_S2_BASE, 8'hff, 1'b0, SPC_NONE}},
    // print screen make broken after the second e0
    '{ROW_BYTE, BYTE_E0, 1'b0, '0},
    '{ROW_BYTE, BYTE_12, 1'b0, '0},
    '{ROW_BYTE, BYTE_E0, 1'b0, '0},
    '{ROW_BYTE, 8'h15,   1'b0, '0},
    // print screen break, whole
    '{ROW_BYTE, BYTE_E0, 1'b0, '0},
    '{ROW_BYTE, BYTE_F0, 1'b0, '0},
    '{ROW_BYTE, BYTE_7C, 1'b0, '0},
    '{ROW_BYTE, BYTE_E0, 1'b0, '0},
    '{ROW_BYTE, BYTE_F0, 1'b0, '0},
    '{ROW_BYTE, BYTE_12, 1'b1, '{TBL_SPECIAL, 8'h00, 1'b1, SPC_PRTSC}},
    // set 3 release goes back to the set 3 base state
    '{ROW_SET,  {6'd0, SET_3}, 1'b0, '0},
    '{ROW_BYTE, BYTE_F0, 1'b0, '0},
    '{ROW_BYTE, 8'h80,   1'b1, '{TBL_S3, 8'h80, 1'b1, SPC_NONE}},
    // set zero written acts as set 1
    '{ROW_SET,  {6'd0, SET_ZERO}, 1'b0, '0},
    '{ROW_BYTE, BYTE_E0, 1'b0, '0},
    '{ROW_BYTE, BYTE_2A, 1'b0, '0},
    '{ROW_BYTE, BYTE_E0, 1'b0, '0},
    '{ROW_BYTE, BYTE_37, 1'b1, '{TBL_SPECIAL, 8'h00, 1'b0, SPC_PRTSC}},
    // set 1 pause, two events on the last byte
    '{ROW_BYTE, BYTE_E1, 1'b0, '0},
    '{ROW_BYTE, BYTE_1D, 1'b0, '0},
    '{ROW_BYTE, BYTE_45, 1'b0, '0},
    '{ROW_BYTE, BYTE_E1, 1'b0, '0},
    '{ROW_BYTE, BYTE_9D, 1'b0, '0},
    '{ROW_BYTE, BYTE_9D, 1'b0, '0}
  };

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // predictor: append one event, at most six per byte
  function automatic void note_event(logic [2:0] tbl, logic [7:0] code, logic rel,
                                     logic [1:0] spec);
    key_event_t e;
    e.table_select = tbl;
    e.key_code     = code;
    e.released     = rel;
    e.special_key  = spec;
    if (byte_events.size() < MAX_EVENTS) byte_events.push_back(e);
  endfunction

  // replay the first n bytes of a broken pause prefix as plain events
  function automatic void replay_pause(logic set_one, int n);
    logic [7:0] one [4] = '{BYTE_E1, BYTE_1D, BYTE_45, BYTE_E1};
    logic [7:0] two [5] = '{BYTE_E1, BYTE_14, BYTE_77, BYTE_E1, BYTE_14};
    for (int k = 0; k < n; k++) begin
      if (set_one) begin
        note_event(TBL_S1_BASE, one[k], 1'b0, SPC_NONE);
      end else begin
        // the fifth set 2 byte stands for f0 14, a release
        note_event(TBL_S2_BASE, two[k], k == 4, SPC_NONE);
      end
    end
  endfunction

  // predictor: events of one scan byte; a broken sequence flushes its bytes
  // and hands the current byte to the state it falls back to
  function automatic void predict_key_events(logic [7:0] b);
    state_t st;
    logic   redo;
    int     passes;
    byte_events.delete();
    st     = prefix_state;
    redo   = 1'b1;
    passes = 0;
    while (redo && passes < 8) begin
      redo = 1'b0;
      passes++;
      case (st)
        ST_S1: begin
          if (b == BYTE_E0) st = ST_S1_E0;
          else if (b == BYTE_E1) st = ST_S1_E1;
          else note_event(TBL_S1_BASE, b, 1'b0, SPC_NONE);
        end
        ST_S1_E0: begin
          if (b == BYTE_2A) st = ST_S1_E0_2A;
          else if (b == BYTE_B7) st = ST_S1_E0_B7;
          else begin
            note_event(TBL_S1_E0, b, 1'b0, SPC_NONE);
            st = ST_S1;
          end
        end
        ST_S1_E0_2A: begin
          if (b == BYTE_E0) st = ST_S1_E0_2A_E0;
          else begin
            note_event(TBL_S1_E0, BYTE_2A, 1'b0, SPC_NONE);
            st = ST_S1; redo = 1'b1;
          end
        end
        ST_S1_E0_2A_E0: begin
          if (b == BYTE_37) begin
            note_event(TBL_SPECIAL, 8'h00, 1'b0, SPC_PRTSC);
            st = ST_S1;
          end else begin
            note_event(TBL_S1_E0, BYTE_2A, 1'b0, SPC_NONE);
            st = ST_S1_E0; redo = 1'b1;
          end
        end
        ST_S1_E0_B7: begin
          if (b == BYTE_E0) st = ST_S1_E0_B7_E0;
          else begin
            note_event(TBL_S1_E0, BYTE_B7, 1'b0, SPC_NONE);
            st = ST_S1; redo = 1'b1;
          end
        end
        ST_S1_E0_B7_E0: begin
          if (b == BYTE_AA) begin
            note_event(TBL_SPECIAL, 8'h00, 1'b1, SPC_PRTSC);
            st = ST_S1;
          end else begin
            note_event(TBL_S1_E0, BYTE_B7, 1'b0, SPC_NONE);
            st = ST_S1_E0; redo = 1'b1;
          end
        end
        ST_S1_E1: begin
          if (b == BYTE_1D) st = ST_S1_P1;
          else begin replay_pause(1'b1, 1); st = ST_S1; redo = 1'b1; end
        end
        ST_S1_P1: begin
          if (b == BYTE_45) st = ST_S1_P2;
          else begin replay_pause(1'b1, 2); st = ST_S1; redo = 1'b1; end
        end
        ST_S1_P2: begin
          if (b == BYTE_E1) st = ST_S1_P3;
          else begin replay_pause(1'b1, 3); st = ST_S1; redo = 1'b1; end
        end
        ST_S1_P3: begin
          if (b == BYTE_9D) st = ST_S1_P4;
          else begin replay_pause(1'b1, 3); st = ST_S1_E1; redo = 1'b1; end
        end
        ST_S1_P4: begin
          st = ST_S1;
          if (b == BYTE_9D) begin
            note_event(TBL_SPECIAL, 8'h00, 1'b0, SPC_PAUSE);
            note_event(TBL_SPECIAL, 8'h00, 1'b1, SPC_PAUSE);
          end else begin
            replay_pause(1'b1, 4); redo = 1'b1;
          end
        end
        ST_S2_F0: begin
          note_event(TBL_S2_BASE, b, 1'b1, SPC_NONE);
          st = ST_S2;
        end
        ST_S2_E0: begin
          if (b == BYTE_F0) st = ST_S2_E0_F0;
          else if (b == BYTE_12) st = ST_S2_E0_12;
          else begin
            note_event(TBL_S2_E0, b, 1'b0, SPC_NONE);
            st = ST_S2;
          end
        end
        ST_S2_E0_F0: begin
          if (b == BYTE_7C) st = ST_S2_R1;
          else begin
            note_event(TBL_S2_E0, b, 1'b1, SPC_NONE);
            st = ST_S2;
          end
        end
        ST_S2_E0_12: begin
          if (b == BYTE_E0) st = ST_S2_E0_12_E0;
          else begin
            note_event(TBL_S2_E0, BYTE_12, 1'b0, SPC_NONE);
            st = ST_S2; redo = 1'b1;
          end
        end
        ST_S2_E0_12_E0: begin
          if (b == BYTE_7C) begin
            note_event(TBL_SPECIAL, 8'h00, 1'b0, SPC_PRTSC);
            st = ST_S2;
          end else begin
            note_event(TBL_S2_E0, BYTE_12, 1'b0, SPC_NONE);
            st = ST_S2_E0; redo = 1'b1;
          end
        end
        ST_S2_R1: begin
          if (b == BYTE_E0) st = ST_S2_R2;
          else begin
            note_event(TBL_S2_E0, BYTE_7C, 1'b1, SPC_NONE);
            st = ST_S2; redo = 1'b1;
          end
        end
        ST_S2_R2: begin
          if (b == BYTE_F0) st = ST_S2_R3;
          else begin
            note_event(TBL_S2_E0, BYTE_7C, 1'b1, SPC_NONE);
            st = ST_S2_E0; redo = 1'b1;
          end
        end
        ST_S2_R3: begin
          if (b == BYTE_12) begin
            note_event(TBL_SPECIAL, 8'h00, 1'b1, SPC_PRTSC);
            st = ST_S2;
          end else begin
            note_event(TBL_S2_E0, BYTE_7C, 1'b1, SPC_NONE);
            st = ST_S2_E0_F0; redo = 1'b1;
          end
        end
        ST_S2_E1: begin
          if (b == BYTE_14) st = ST_S2_P1;
          else begin replay_pause(1'b0, 1); st = ST_S2; redo = 1'b1; end
        end
        ST_S2_P1: begin
          if (b == BYTE_77) st = ST_S2_P2;
          else begin replay_pause(1'b0, 2); st = ST_S2; redo = 1'b1; end
        end
        ST_S2_P2: begin
          if (b == BYTE_E1) st = ST_S2_P3;
          else begin replay_pause(1'b0, 3); st = ST_S2; redo = 1'b1; end
        end
        ST_S2_P3: begin
          if (b == BYTE_F0) st = ST_S2_P4;
          else begin replay_pause(1'b0, 3); st = ST_S2_E1; redo = 1'b1; end
        end
        ST_S2_P4: begin
          if (b == BYTE_14) st = ST_S2_P5;
          else begin replay_pause(1'b0, 4); st = ST_S2_F0; redo = 1'b1; end
        end
        ST_S2_P5: begin
          if (b == BYTE_F0) st = ST_S2_P6;
          else begin replay_pause(1'b0, 5); st = ST_S2; redo = 1'b1; end
        end
        ST_S2_P6: begin
          if (b == BYTE_12) begin
            note_event(TBL_SPECIAL, 8'h00, 1'b0, SPC_PAUSE);
            note_event(TBL_SPECIAL, 8'h00, 1'b1, SPC_PAUSE);
            st = ST_S2;
          end else begin
            replay_pause(1'b0, 5); st = ST_S2_F0; redo = 1'b1;
          end
        end
        ST_S3: begin
          if (b == BYTE_F0) st = ST_S3_F0;
          else note_event(TBL_S3, b, 1'b0, SPC_NONE);
        end
        ST_S3_F0: begin
          note_event(TBL_S3, b, 1'b1, SPC_NONE);
          st = ST_S3;
        end
        default: begin  // set 2 base
          if (b == BYTE_F0) st = ST_S2_F0;
          else if (b == BYTE_E0) st = ST_S2_E0;
          else if (b == BYTE_E1) st = ST_S2_E1;
          else begin
            note_event(TBL_S2_BASE, b, 1'b0, SPC_NONE);
            st = ST_S2;
          end
        end
      endcase
    end
    prefix_state = st;
  endfunction

  // offer one scan byte after a random gap; at acceptance queue what it must produce
  task automatic send_scan_byte(input logic [7:0] b, input logic typed,
                                input key_event_t typed_ev);
    int        gap;
    key_word_t w;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      scan_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    scan_ch.valid     <= 1'b1;
    scan_ch.scan_byte <= b;
    @(posedge clk);
    while (!scan_ch.ready) @(posedge clk);
    bytes_sent++;
    predict_key_events(b);
    if (typed) begin
      w.ev      = typed_ev;
      w.last_ev = 1'b1;
      key_words_due.push_back(w);
    end else begin
      foreach (byte_events[i]) begin
        w.ev      = byte_events[i];
        w.last_ev = (i == byte_events.size() - 1);
        key_words_due.push_back(w);
      end
    end
    @(negedge clk);
  endtask

  // scan set write: only once every expected word is out and the input has settled
  task automatic write_scan_set(input logic [1:0] v);
    scan_ch.valid <= 1'b0;
    while (key_words_due.size() != 0) @(negedge clk);
    // prefix bytes leave no word behind, so give them time to clear the block
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_set = (v == SET_ZERO) ? SET_1 : v;
    if (active_set == SET_3) prefix_state = ST_S3;
    else if (active_set == SET_2) prefix_state = ST_S2;
    else prefix_state = ST_S1;
  endtask

  // build one random sequence for the current set: mostly well-formed keys and
  // special sequences, some bare noise, some sequences cut short
  task automatic queue_sequence();
    logic [7:0] seq [$];
    logic [7:0] k;
    int         pick;
    int         sub;
    int         cut;
    pick = $urandom_range(0, 99);
    k    = 8'($urandom_range(0, 255));
    if (pick < 15) begin
      stim_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (active_set == SET_3) begin
        if ($urandom_range(0, 1) == 0) seq = '{k};
        else seq = '{BYTE_F0, k};
      end else if (active_set == SET_1) begin
        sub = (pick >= 85) ? $urandom_range(2, 4) : $urandom_range(0, 4);
        case (sub)
          0: seq = '{k};
          1: seq = '{BYTE_E0, k};
          2: seq = '{BYTE_E0, BYTE_2A, BYTE_E0, BYTE_37};
          3: seq = '{BYTE_E0, BYTE_B7, BYTE_E0, BYTE_AA};
          default: seq = '{BYTE_E1, BYTE_1D, BYTE_45, BYTE_E1, BYTE_9D, BYTE_9D};
        endcase
      end else begin
        sub = (pick >= 85) ? $urandom_range(4, 6) : $urandom_range(0, 6);
        case (sub)
          0: seq = '{k};
          1: seq = '{BYTE_F0, k};
          2: seq = '{BYTE_E0, k};
          3: seq = '{BYTE_E0, BYTE_F0, k};
          4: seq = '{BYTE_E0, BYTE_12, BYTE_E0, BYTE_7C};
          5: seq = '{BYTE_E0, BYTE_F0, BYTE_7C, BYTE_E0, BYTE_F0, BYTE_12};
          default: seq = '{BYTE_E1, BYTE_14, BYTE_77, BYTE_E1, BYTE_F0, BYTE_14,
                           BYTE_F0, BYTE_12};
        endcase
      end
      // broken sequence: keep a prefix, then a random byte breaks it off
      if (pick >= 85 && seq.size() > 1) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
        seq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (seq[i]) stim_bytes.push_back(seq[i]);
    end
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    key_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        key_ch.ready <= 1'b0;
      end else begin
        key_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // checker: each accepted key word against the oldest expectation
  always @(posedge clk) begin : key_word_check
    key_word_t want;
    if (!rst && key_ch.valid && key_ch.ready) begin
      if (key_words_due.size() == 0) begin
        $error("key word with none expected: table_select %0d key_code %02h",
               key_ch.table_select, key_ch.key_code);
        mismatch_count++;
      end else begin
        want = key_words_due.pop_front();
        events_checked++;
        if (key_ch.table_select !== want.ev.table_select) begin
          $error("table_select expected %0d got %0d", want.ev.table_select,
                 key_ch.table_select);
          mismatch_count++;
        end
        if (key_ch.key_code !== want.ev.key_code) begin
          $error("key_code expected %02h got %02h", want.ev.key_code, key_ch.key_code);
          mismatch_count++;
        end
        if (key_ch.released !== want.ev.released) begin
          $error("released expected %0b got %0b", want.ev.released, key_ch.released);
          mismatch_count++;
        end
        if (key_ch.special_key !== want.ev.special_key) begin
          $error("special_key expected %0d got %0d", want.ev.special_key,
                 key_ch.special_key);
          mismatch_count++;
        end
        if (key_ch.last_event !== want.last_ev) begin
          $error("last_event expected %0b got %0b", want.last_ev, key_ch.last_event);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    int phase_bytes;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = SET_2;
    scan_ch.valid     = 1'b0;
    scan_ch.scan_byte = 8'h00;
    hold_armed        = 1'b0;
    hold_started      = 1'b0;
    hold_left         = 0;
    mismatch_count    = 0;
    bytes_sent        = 0;
    events_checked    = 0;
    cycle_count       = 0;
    // after reset the block sits in the set 2 base state
    active_set        = SET_2;
    prefix_state      = ST_S2;
    // sender idles lightly, receiver heavily
    src_idle_pct      = 10;
    sink_idle_pct     = 55;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SET) begin
        write_scan_set(directed_rows[i].value[1:0]);
      end else begin
        send_scan_byte(directed_rows[i].value, directed_rows[i].typed,
                       directed_rows[i].typed_ev);
      end
    end

    // random phases, each opened by a scan set write
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph < 2) begin
        src_idle_pct  = 10;
        sink_idle_pct = 55;
      end else if (ph < 4) begin
        src_idle_pct  = 55;
        sink_idle_pct = 10;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_scan_set(PHASE_SET[ph]);
      // full-rate sender against a stalled receiver: block fills and stalls scan
      if (ph == 4) hold_armed = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        queue_sequence();
        while (stim_bytes.size() != 0) begin
          send_scan_byte(stim_bytes.pop_front(), 1'b0, '0);
          phase_bytes++;
        end
      end
    end

    // drain, then watch a little longer for anything extra
    scan_ch.valid <= 1'b0;
    while (key_words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d scan bytes and %0d key words over scan sets 0 to 3,",
             bytes_sent, events_checked);
    $display("with broken prefixes, print screen, pause and a long receiver stall");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ps2d_pkg.sv
sv/ps2d_byte_if.sv
sv/ps2d_event_if.sv
sv/ps2d_decode.sv
sv/ps2d_event_queue.sv
sv/ps2_scan_code_prefix_decoder_top.sv
verif/ps2_scan_code_prefix_decoder_top_test.sv
